@@ rtl/hbd_pkg.sv @@
// shared types, constants and helper functions for the http body dechunker
// no dependencies
`default_nettype none

package hbd_pkg;

    localparam int SIZE_BITS_DEF   = 32;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int MAX_BODY_BITS   = 32;
    localparam logic [MAX_BODY_BITS-1:0] MAX_BODY_RESET = 32'd1048576;

    // header text that switches the body to chunked mode
    localparam int MARKER_LEN = 26;
    localparam int MARKER_CNT_BITS = $clog2(MARKER_LEN + 1);
    localparam logic [8*MARKER_LEN-1:0] TE_MARKER = "Transfer-Encoding: chunked";

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_FRAMING   = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_PLAIN,
        PH_LINE_START,
        PH_LEAD,
        PH_DIGITS,
        PH_REST,
        PH_CR,
        PH_DATA,
        PH_TRAIL,
        PH_DONE
    } hbd_phase_t;

    // header scanner to framer
    typedef struct packed {
        logic blank_done;
        logic chunked;
    } hbd_hdr_t;

    // framer result for the byte in the input register
    typedef struct packed {
        logic       has_result;
        logic       body_valid;
        logic       eom;
        logic [1:0] status;
    } hbd_res_t;

    function automatic logic [7:0] marker_char(input logic [MARKER_CNT_BITS-1:0] idx);
        logic [7:0] c;
        int         pos;
        c   = 8'h00;
        pos = MARKER_LEN - 1 - int'(idx);
        if (int'(idx) < MARKER_LEN) begin
            c = TE_MARKER[8*pos +: 8];
        end
        return c;
    endfunction

    function automatic logic hex_ok(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= "0" && b <= "9") begin
            v = b - 8'h30;
        end else if (b >= "a" && b <= "f") begin
            v = b - 8'h57;
        end else if (b >= "A" && b <= "F") begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [1:0] raise_status(input logic [1:0] cur, input logic [1:0] s);
        return (s > cur) ? s : cur;
    endfunction

endpackage

`default_nettype wire

@@ rtl/http_body_dechunker.sv @@
// HTTP body dechunker: takes a request one byte per transaction and passes
// on the decoded body bytes. Throughput is one byte per clock while the output
// is not held by m_axis_tready; a byte sits in the input register while the
// framer decides on it, and its result is then registered in the output
// register. Bytes that produce no result (header, size lines, chunk trailers)
// are also taken at one per clock and never wait on the output. Status is sticky
// per message and clears after the transaction marked tlast. Write cfg_wdata (max body length) only while idle.
// depends on hbd_pkg, hbd_framer, hbd_hdr_scan
`default_nettype none

module http_body_dechunker
    import hbd_pkg::*;
#(
    parameter int SIZE_BITS   = SIZE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [MAX_BODY_BITS-1:0] cfg_wdata,   // max_body_bytes
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [7:0]               s_axis_tdata,    // [7:0] data_byte
    input  wire logic                     s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [7:0]                    m_axis_tdata,    // [7:0] body_byte
    output logic [2:0]                    m_axis_tuser,    // [0] body_valid, [2:1] status
    output logic                          m_axis_tlast
);

    logic [MAX_BODY_BITS-1:0] max_body_reg;
    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic                     out_valid_reg;
    logic [7:0]               out_byte_reg;
    logic [2:0]               out_user_reg;
    logic                     out_last_reg;
    logic                     out_free, step;
    hbd_res_t                 res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= MAX_BODY_RESET;
        end else if (cfg_we) begin
            max_body_reg <= cfg_wdata;
        end
    end

    hbd_framer #(
        .SIZE_BITS   (SIZE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .byte_in        (in_byte_reg),
        .last_in        (in_last_reg),
        .max_body_bytes (max_body_reg),
        .res            (res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!res.has_result || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && res.has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res.has_result) begin
            out_byte_reg <= res.body_valid ? in_byte_reg : 8'h00;
            out_user_reg <= {res.status, res.body_valid};
            out_last_reg <= res.eom;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.has_result) |-> out_free)
        else $error("result register overwritten");

    // a result without a body byte only exists to mark the end of a message
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
        else $error("empty result not marking end of message");

    // status code three is never produced
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[2:1] != 2'd3))
        else $error("invalid status code");
`endif

endmodule

`default_nettype wire

@@ rtl/hbd_hdr_scan.sv @@
// header section scanner: transfer-encoding marker and blank line detection
// depends on hbd_pkg
`default_nettype none

module hbd_hdr_scan
    import hbd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic       active,
    input  wire logic       clear,
    input  wire logic [7:0] byte_in,
    output hbd_hdr_t        hdr
);

    logic [MARKER_CNT_BITS-1:0] mcnt_reg, mcnt_next;
    logic [1:0]                 blank_reg, blank_next;
    logic                       chunked_reg, chunked_next;
    logic [7:0]                 expect_ch;

    always_comb begin
        mcnt_next    = mcnt_reg;
        chunked_next = chunked_reg;
        if (int'(mcnt_reg) < MARKER_LEN) begin
            if (byte_in == marker_char(mcnt_reg)) begin
                mcnt_next = mcnt_reg + 1'b1;
            end else if (byte_in == marker_char('0)) begin
                mcnt_next = MARKER_CNT_BITS'(1);
            end else begin
                mcnt_next = '0;
            end
            if (int'(mcnt_next) == MARKER_LEN) begin
                chunked_next = 1'b1;
            end
        end
    end

    // blank line match: cr lf cr lf
    always_comb begin
        expect_ch      = blank_reg[0] ? CHAR_LF : CHAR_CR;
        hdr.blank_done = 1'b0;
        if (byte_in == expect_ch) begin
            if (blank_reg == 2'd3) begin
                blank_next     = 2'd0;
                hdr.blank_done = 1'b1;
            end else begin
                blank_next = blank_reg + 2'd1;
            end
        end else begin
            blank_next = (byte_in == CHAR_CR) ? 2'd1 : 2'd0;
        end
        hdr.chunked = chunked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            mcnt_reg    <= '0;
            blank_reg   <= '0;
            chunked_reg <= 1'b0;
        end else if (step && active) begin
            mcnt_reg    <= mcnt_next;
            blank_reg   <= blank_next;
            chunked_reg <= chunked_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hbd_framer.sv @@
// body framing: plain or chunked body, size lines, length limit and status
// depends on hbd_pkg and hbd_hdr_scan
`default_nettype none

module hbd_framer
    import hbd_pkg::*;
#(
    parameter int SIZE_BITS   = SIZE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step,
    input  wire logic [7:0]               byte_in,
    input  wire logic                     last_in,
    input  wire logic [MAX_BODY_BITS-1:0] max_body_bytes,
    output hbd_res_t                      res
);

    localparam int CW = (LENGTH_BITS > MAX_BODY_BITS) ? LENGTH_BITS : MAX_BODY_BITS;

    hbd_phase_t             phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next, size_dec;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [1:0]             err_reg, err_next, err_mid;
    hbd_hdr_t               hdr;
    logic                   is_hex, digit_take, too_full, pass_phase, bad_end;
    logic [3:0]             hv;

    hbd_hdr_scan u_hdr_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .active  (phase_reg == PH_HEADER),
        .clear   (last_in),
        .byte_in (byte_in),
        .hdr     (hdr)
    );

    assign is_hex     = hex_ok(byte_in);
    assign hv         = hex_val(byte_in);
    assign digit_take = is_hex && (phase_reg == PH_LINE_START || phase_reg == PH_LEAD ||
                                   phase_reg == PH_DIGITS);
    assign too_full   = (CW'(len_reg) >= CW'(max_body_bytes)) || (&len_reg);
    assign pass_phase = (phase_reg == PH_PLAIN) || (phase_reg == PH_DATA);
    assign size_dec   = size_reg - 1'b1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg) inside
            PH_HEADER: begin
                if (hdr.blank_done) begin
                    phase_next = hdr.chunked ? PH_LINE_START : PH_PLAIN;
                end
            end
            PH_LINE_START, PH_LEAD, PH_DIGITS, PH_REST, PH_CR: begin
                if (phase_reg == PH_CR && byte_in == CHAR_LF) begin
                    phase_next = (size_reg == '0) ? PH_DONE : PH_DATA;
                end else if (byte_in == CHAR_CR) begin
                    phase_next = PH_CR;
                end else if (phase_reg == PH_LINE_START || phase_reg == PH_LEAD) begin
                    if (byte_in == CHAR_SPACE) begin
                        phase_next = PH_LEAD;
                    end else if (is_hex) begin
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_REST;
                    end
                end else if (phase_reg == PH_DIGITS && is_hex) begin
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_REST;
                end
            end
            PH_DATA: begin
                if (size_dec == '0) begin
                    phase_next = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (size_dec == '0) begin
                    phase_next = PH_LINE_START;
                end
            end
            PH_PLAIN, PH_DONE: phase_next = phase_reg;
            default:           phase_next = PH_HEADER;
        endcase
    end

    // counters, status and result
    always_comb begin
        size_next = size_reg;
        len_next  = len_reg;
        err_mid   = err_reg;
        if (digit_take && byte_in != CHAR_CR) begin
            if (|size_reg[SIZE_BITS-1 -: 4]) begin
                size_next = '1;
                err_mid   = raise_status(err_reg, ST_FRAMING);
            end else begin
                size_next = {size_reg[SIZE_BITS-5:0], hv};
            end
        end
        if (pass_phase) begin
            if (too_full) begin
                err_mid = raise_status(err_reg, ST_TOO_LARGE);
            end else begin
                len_next = len_reg + 1'b1;
            end
        end
        if (phase_reg == PH_DATA) begin
            size_next = (size_dec == '0) ? SIZE_BITS'(2) : size_dec;
        end else if (phase_reg == PH_TRAIL) begin
            size_next = size_dec;
        end
        // message ends in the header, a started size line or inside chunk data
        bad_end = last_in && (phase_next == PH_HEADER || phase_next == PH_LEAD ||
                              phase_next == PH_DIGITS || phase_next == PH_REST ||
                              phase_next == PH_CR || phase_next == PH_DATA);
        err_next = bad_end ? raise_status(err_mid, ST_FRAMING) : err_mid;

        res.body_valid = pass_phase && !too_full;
        res.eom        = last_in;
        res.has_result = res.body_valid || last_in;
        res.status     = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_in)) begin
            phase_reg <= PH_HEADER;
            size_reg  <= '0;
            len_reg   <= '0;
            err_reg   <= ST_OK;
        end else if (step) begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire
